@@ rtl/bcc_pkg.sv @@
`default_nettype none

package bcc_pkg;

  // field widths
  localparam int unsigned NowW    = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned EventW  = 2;

  // padded stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // phase codes
  localparam logic [PhaseW-1:0] PhStandby  = 2'd0;
  localparam logic [PhaseW-1:0] PhPressed  = 2'd1;
  localparam logic [PhaseW-1:0] PhReleased = 2'd2;
  localparam logic [PhaseW-1:0] PhIdle     = 2'd3;

  // event codes
  localparam logic [EventW-1:0] EvNone   = 2'd0;
  localparam logic [EventW-1:0] EvShort  = 2'd1;
  localparam logic [EventW-1:0] EvLong   = 2'd2;
  localparam logic [EventW-1:0] EvDouble = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDoubleClick = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressedLvl  = 2'd3;

  // register reset values
  localparam logic [CfgW-1:0] DebounceRst    = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst   = 16'd1000;
  localparam logic [CfgW-1:0] DoubleClickRst = 16'd300;
  localparam logic            PressedLvlRst  = 1'b0;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_click_ms;
    logic            pressed_level;
  } cfg_t;

  typedef struct packed {
    logic [NowW-1:0] now_ms;
    logic            pin_level;
  } poll_t;

endpackage

`default_nettype wire

@@ rtl/bcc_fsm.sv @@
`default_nettype none

module bcc_fsm (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire bcc_pkg::poll_t               poll_i,
  input  wire bcc_pkg::cfg_t                cfg_i,
  output logic [bcc_pkg::EventW-1:0]        event_o
);

  logic [bcc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [bcc_pkg::NowW-1:0]   stamp_q, stamp_d;
  logic [bcc_pkg::NowW-1:0]   elapsed;
  logic                       down;
  logic                       sample;

  // wrapping elapsed time and debounce gate
  assign down    = (poll_i.pin_level == cfg_i.pressed_level);
  assign elapsed = poll_i.now_ms - stamp_q;
  assign sample  = (elapsed >= {{(bcc_pkg::NowW-bcc_pkg::CfgW){1'b0}}, cfg_i.debounce_ms});

  // phase decision
  always_comb begin
    phase_d = phase_q;
    stamp_d = stamp_q;
    event_o = bcc_pkg::EvNone;
    if (sample) begin
      case (phase_q)
        bcc_pkg::PhStandby: begin
          if (down) phase_d = bcc_pkg::PhPressed;
          stamp_d = poll_i.now_ms;
        end
        bcc_pkg::PhPressed: begin
          if (!down) begin
            phase_d = bcc_pkg::PhReleased;
            stamp_d = poll_i.now_ms;
          end else if (elapsed >= {{(bcc_pkg::NowW-bcc_pkg::CfgW){1'b0}},
                                   cfg_i.long_press_ms}) begin
            event_o = bcc_pkg::EvLong;
            phase_d = bcc_pkg::PhIdle;
            stamp_d = poll_i.now_ms;
          end
        end
        bcc_pkg::PhReleased: begin
          if (elapsed <= {{(bcc_pkg::NowW-bcc_pkg::CfgW){1'b0}},
                          cfg_i.double_click_ms}) begin
            if (down) begin
              event_o = bcc_pkg::EvDouble;
              phase_d = bcc_pkg::PhIdle;
              stamp_d = poll_i.now_ms;
            end
          end else begin
            event_o = bcc_pkg::EvShort;
            phase_d = bcc_pkg::PhIdle;
            stamp_d = poll_i.now_ms;
          end
        end
        default: begin
          if (!down) phase_d = bcc_pkg::PhStandby;
          stamp_d = poll_i.now_ms;
        end
      endcase
    end
  end

  // phase and stamp registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcc_pkg::PhStandby;
      stamp_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/button_click_classifier_top.sv @@
// button click classifier
// slave stream: one word per poll of the button pin; master stream: one
// word per poll carrying the event code (none, short, long, double click).
// configuration: write enable, register index and 16-bit data; the user must
// write registers only while no poll is in flight; the block does not enforce it.
// pipeline: an input register holds the accepted poll; when it advances,
// the classifier compares the wrapping elapsed time against the
// configured periods, updates phase and stamp, and loads the output
// register, which then presents the event word.
// throughput is one poll per cycle while the receiver does not stall; the
// phase/stamp update is combinational: one 32-bit subtract and a few compares.
// when the receiver stalls the output register holds its word, the input
// register fills, and s_tready drops only once both are occupied.
// reset clears both valid flags, returns the phase to standby with a
// zero stamp and loads the registers with their default periods.
`default_nettype none

module button_click_classifier_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [bcc_pkg::CfgW-1:0]         cfg_data_i,
  // poll stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bcc_pkg::InDataW-1:0]      s_tdata,   // now_ms[31:0], pin_level[32]
  // event stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [bcc_pkg::OutDataW-1:0]          m_tdata    // event_code[1:0]
);

  bcc_pkg::cfg_t              cfg_q;
  bcc_pkg::poll_t             poll_q;
  logic                       in_valid_q;
  logic                       out_valid_q;
  logic [bcc_pkg::EventW-1:0] event_q;
  logic [bcc_pkg::EventW-1:0] event_d;
  logic                       advance;
  logic                       in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= bcc_pkg::DebounceRst;
      cfg_q.long_press_ms   <= bcc_pkg::LongPressRst;
      cfg_q.double_click_ms <= bcc_pkg::DoubleClickRst;
      cfg_q.pressed_level   <= bcc_pkg::PressedLvlRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcc_pkg::RegDebounce:    cfg_q.debounce_ms     <= cfg_data_i;
        bcc_pkg::RegLongPress:   cfg_q.long_press_ms   <= cfg_data_i;
        bcc_pkg::RegDoubleClick: cfg_q.double_click_ms <= cfg_data_i;
        bcc_pkg::RegPressedLvl:  cfg_q.pressed_level   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;
  assign in_take  = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q.now_ms    <= s_tdata[bcc_pkg::NowW-1:0];
      poll_q.pin_level <= s_tdata[bcc_pkg::NowW];
    end
  end

  // classifier
  bcc_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .poll_i  (poll_q),
    .cfg_i   (cfg_q),
    .event_o (event_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {{(bcc_pkg::OutDataW-bcc_pkg::EventW){1'b0}}, event_q};

endmodule

`default_nettype wire
